// ===== sv/fsr_pkg.sv =====
// shared types and constants for the frame store shape rasterizer
package fsr_pkg;

    localparam int SIDE     = 128;
    localparam int COORD_W  = $clog2(SIDE);
    localparam int ADDR_W   = 2 * COORD_W;
    localparam int DEPTH    = SIDE * SIDE;

    typedef enum logic [3:0] {
        CMD_CLEAR  = 4'd0,
        CMD_PIXEL  = 4'd1,
        CMD_HSPAN  = 4'd2,
        CMD_VSPAN  = 4'd3,
        CMD_RECT   = 4'd4,
        CMD_FRECT  = 4'd5,
        CMD_CIRC   = 4'd6,
        CMD_FCIRC  = 4'd7,
        CMD_READ   = 4'd8
    } cmd_t;

    typedef enum logic [1:0] {
        ORI_ROT180 = 2'd0,
        ORI_NONE   = 2'd1,
        ORI_LEFT   = 2'd2,
        ORI_RIGHT  = 2'd3
    } ori_t;

    // pack rgb components into the stored 16-bit word
    function automatic logic [15:0] pack_word(input logic [5:0] r, input logic [5:0] g,
                                              input logic [5:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {b[4:0], g[5:3]};
        lo = {g[2:0], r[4:0]};
        return {hi, lo};
    endfunction

endpackage

// ===== sv/framebuffer_shape_rasterizer_unit.sv =====
// Frame store shape rasterizer: a 128x128 frame memory drawn by shape commands, one pixel
// per cycle. A command beat is accepted only when the unit is idle and no result waits.
// Circles plot 8 points (outline) or four spans (filled) per row after a square root per
// row, and a clear writes all 16384 words; the single write port of the frame memory sets
// the pace. The result beat (zero, or the stored word for a read) waits in an output
// register. The memory holds no reset value: clear it before reading.
module framebuffer_shape_rasterizer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_cmd,
    input  logic [7:0]  s_x,
    input  logic [7:0]  s_y,
    input  logic [7:0]  s_a,
    input  logic [7:0]  s_b,
    input  logic [5:0]  s_red,
    input  logic [5:0]  s_green,
    input  logic [5:0]  s_blue,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_pixel_word
);

    localparam int AW = fsr_pkg::ADDR_W;
    localparam int CW = fsr_pkg::COORD_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_SPAN, ST_SQRT, ST_PLOT8, ST_FSPAN, ST_READ, ST_DONE
    } state_t;

    // span kinds used by the generic span walker
    typedef enum logic [1:0] { SP_H, SP_V, SP_FRECT, SP_RECT } span_t;

    logic [15:0] mem [fsr_pkg::DEPTH];
    logic [15:0] rd_data;
    logic [AW-1:0] rd_addr;
    logic        rd_en;

    logic        wr_en;
    logic [AW-1:0] wr_addr;

    state_t      state_reg;
    logic [1:0]  ori_reg;
    logic [3:0]  cmd_reg;
    logic [7:0]  x_reg, y_reg, a_reg, b_reg;
    logic [15:0] word_reg;
    logic [15:0] out_reg;
    logic        out_valid_reg;

    // span walker: current point (px,py), count remaining
    span_t       sk_reg;
    logic [7:0]  px_reg, py_reg;
    logic [7:0]  cnt_reg;      // inner count
    logic [7:0]  row_reg;      // outer count for filled rect
    logic [1:0]  seg_reg;      // rect outline segment / fcircle span index
    logic [AW:0] clr_reg;

    // circle state
    logic [7:0]  ci_reg;       // row index i
    logic [7:0]  cr_reg;       // r'
    logic [7:0]  t_reg;
    logic [2:0]  pt_reg;
    // square root unit
    logic [15:0] sq_rem_reg, sq_res_reg, sq_bit_reg, sq_n_reg;
    logic [3:0]  sq_step_reg;

    // plotted point this cycle
    logic        plot_en;
    logic [7:0]  plot_x, plot_y;

    always_comb begin
        logic [7:0] tx, ty;
        tx = plot_x;
        ty = plot_y;
        wr_en = 1'b0;
        wr_addr = '0;
        if (plot_en && tx < 8'(fsr_pkg::SIDE) && ty < 8'(fsr_pkg::SIDE)) begin
            wr_en = 1'b1;
            unique case (fsr_pkg::ori_t'(ori_reg))
                fsr_pkg::ORI_ROT180: begin
                    tx = 8'(fsr_pkg::SIDE - 1) - plot_x;
                    ty = 8'(fsr_pkg::SIDE - 1) - plot_y;
                end
                fsr_pkg::ORI_LEFT: begin
                    tx = 8'(fsr_pkg::SIDE - 1) - plot_y;
                    ty = plot_x;
                end
                fsr_pkg::ORI_RIGHT: begin
                    tx = plot_y;
                    ty = 8'(fsr_pkg::SIDE - 1) - plot_x;
                end
                default: ;
            endcase
            wr_addr = {ty[CW-1:0], tx[CW-1:0]};
        end
        if (state_reg == ST_CLEAR) begin
            wr_en = 1'b1;
            wr_addr = clr_reg[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= word_reg;
        if (rd_en) rd_data <= mem[rd_addr];
    end

    assign rd_en   = (state_reg == ST_IDLE) && s_valid && s_ready;
    assign rd_addr = {s_y[CW-1:0], s_x[CW-1:0]};

    // point walked by span states, or the circle point chosen in ST_PLOT8
    always_comb begin
        plot_en = 1'b0;
        plot_x = px_reg;
        plot_y = py_reg;
        if (state_reg == ST_SPAN || state_reg == ST_FSPAN) begin
            plot_en = (cnt_reg != 8'd0);
        end else if (state_reg == ST_PLOT8) begin
            plot_en = 1'b1;
            case (pt_reg)
                3'd0: begin plot_x = x_reg - t_reg;  plot_y = y_reg + ci_reg; end
                3'd1: begin plot_x = x_reg - ci_reg; plot_y = y_reg + t_reg;  end
                3'd2: begin plot_x = x_reg + ci_reg; plot_y = y_reg + t_reg;  end
                3'd3: begin plot_x = x_reg + t_reg;  plot_y = y_reg + ci_reg; end
                3'd4: begin plot_x = x_reg + t_reg;  plot_y = y_reg - ci_reg; end
                3'd5: begin plot_x = x_reg + ci_reg; plot_y = y_reg - t_reg;  end
                3'd6: begin plot_x = x_reg - ci_reg; plot_y = y_reg - t_reg;  end
                default: begin plot_x = x_reg - t_reg; plot_y = y_reg - ci_reg; end
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_valid      = out_valid_reg;
    assign m_pixel_word = out_reg;

    // filled-circle span k setup: start point and length
    function automatic logic [23:0] fspan_setup(input logic [1:0] k, input logic [7:0] cx,
                                                input logic [7:0] cy, input logic [7:0] i,
                                                input logic [7:0] t);
        logic [7:0] lo, hi, fx, fy;
        lo = (k[1] ? cy : cx) - t;
        hi = (k[1] ? cy : cx) + t;
        if (lo > hi) begin
            fx = lo; lo = hi; hi = fx;
        end
        case (k)
            2'd0: begin fx = lo;     fy = cy + i; end
            2'd1: begin fx = lo;     fy = cy - i; end
            2'd2: begin fx = cx + i; fy = lo;     end
            default: begin fx = cx - i; fy = lo; end
        endcase
        return {fx, fy, 8'(hi - lo)};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ori_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) ori_reg <= cfg_wdata;
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        cmd_reg  <= s_cmd;
                        x_reg    <= s_x;
                        y_reg    <= s_y;
                        a_reg    <= s_a;
                        b_reg    <= s_b;
                        word_reg <= fsr_pkg::pack_word(s_red, s_green, s_blue);
                        clr_reg  <= '0;
                        seg_reg  <= 2'd0;
                        ci_reg   <= 8'd0;
                        cr_reg   <= s_a - 8'd1;
                        case (s_cmd)
                            fsr_pkg::CMD_CLEAR: state_reg <= ST_CLEAR;
                            fsr_pkg::CMD_PIXEL: begin
                                sk_reg <= SP_H; px_reg <= s_x; py_reg <= s_y;
                                cnt_reg <= 8'd1; state_reg <= ST_SPAN;
                            end
                            fsr_pkg::CMD_HSPAN: begin
                                sk_reg <= SP_H; py_reg <= s_y;
                                px_reg <= (s_x > s_a) ? s_a : s_x;
                                cnt_reg <= (s_x > s_a) ? s_x - s_a : s_a - s_x;
                                state_reg <= ST_SPAN;
                            end
                            fsr_pkg::CMD_VSPAN: begin
                                sk_reg <= SP_V; px_reg <= s_x;
                                py_reg <= (s_y > s_a) ? s_a : s_y;
                                cnt_reg <= (s_y > s_a) ? s_y - s_a : s_a - s_y;
                                state_reg <= ST_SPAN;
                            end
                            fsr_pkg::CMD_RECT: begin
                                sk_reg <= SP_RECT; px_reg <= s_x; py_reg <= s_y;
                                cnt_reg <= s_a; state_reg <= ST_SPAN;
                            end
                            fsr_pkg::CMD_FRECT: begin
                                sk_reg <= SP_FRECT; px_reg <= s_x; py_reg <= s_y;
                                cnt_reg <= s_a; row_reg <= s_b;
                                state_reg <= (s_b == 8'd0) ? ST_DONE : ST_SPAN;
                            end
                            fsr_pkg::CMD_CIRC, fsr_pkg::CMD_FCIRC: begin
                                state_reg <= ST_DONE;
                                if (s_a > 8'd1) begin
                                    sq_n_reg    <= 16'((s_a - 8'd1) * (s_a - 8'd1));
                                    sq_step_reg <= 4'd0;
                                    state_reg   <= ST_SQRT;
                                end
                            end
                            fsr_pkg::CMD_READ: state_reg <= ST_READ;
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg[AW-1:0] == AW'(fsr_pkg::DEPTH - 1)) state_reg <= ST_DONE;
                end
                ST_SPAN: begin
                    if (cnt_reg > 8'd1) begin
                        cnt_reg <= cnt_reg - 8'd1;
                        if (sk_reg == SP_V) py_reg <= py_reg + 8'd1;
                        else if (sk_reg == SP_RECT) begin
                            case (seg_reg)
                                2'd0: px_reg <= px_reg + 8'd1;
                                2'd1: py_reg <= py_reg + 8'd1;
                                2'd2: px_reg <= px_reg - 8'd1;
                                default: py_reg <= py_reg - 8'd1;
                            endcase
                        end else px_reg <= px_reg + 8'd1;
                    end else if (sk_reg == SP_RECT) begin
                        // next outline edge
                        seg_reg <= seg_reg + 2'd1;
                        case (seg_reg)
                            2'd0: begin
                                px_reg <= x_reg + a_reg; py_reg <= y_reg; cnt_reg <= b_reg;
                            end
                            2'd1: begin
                                px_reg <= x_reg + a_reg; py_reg <= y_reg + b_reg;
                                cnt_reg <= a_reg;
                            end
                            2'd2: begin
                                px_reg <= x_reg; py_reg <= y_reg + b_reg; cnt_reg <= b_reg;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end else if (sk_reg == SP_FRECT && row_reg > 8'd1) begin
                        row_reg <= row_reg - 8'd1;
                        px_reg  <= x_reg;
                        py_reg  <= py_reg + 8'd1;
                        cnt_reg <= a_reg;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_SQRT: begin
                    // one digit pair per cycle, then rounding
                    if (sq_step_reg == 4'd0) begin
                        sq_rem_reg <= sq_n_reg - 16'(ci_reg * ci_reg);
                        sq_n_reg   <= sq_n_reg - 16'(ci_reg * ci_reg);
                        sq_res_reg <= '0;
                        sq_bit_reg <= 16'h4000;
                        sq_step_reg <= 4'd1;
                    end else if (sq_bit_reg != 16'd0) begin
                        if (sq_rem_reg >= sq_res_reg + sq_bit_reg) begin
                            sq_rem_reg <= sq_rem_reg - (sq_res_reg + sq_bit_reg);
                            sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                        end else begin
                            sq_res_reg <= sq_res_reg >> 1;
                        end
                        sq_bit_reg <= sq_bit_reg >> 2;
                    end else begin
                        // n >= res^2+res+1  <=>  rem > res
                        t_reg  <= 8'(sq_res_reg) + 8'(sq_rem_reg > sq_res_reg);
                        pt_reg <= 3'd0;
                        seg_reg <= 2'd0;
                        state_reg <= (cmd_reg == fsr_pkg::CMD_CIRC) ? ST_PLOT8 : ST_FSPAN;
                        if (cmd_reg != fsr_pkg::CMD_CIRC) cnt_reg <= 8'd0;
                        sq_n_reg <= sq_n_reg + 16'(ci_reg * ci_reg);
                    end
                end
                ST_PLOT8: begin
                    pt_reg <= pt_reg + 3'd1;
                    if (pt_reg == 3'd7) begin
                        ci_reg <= ci_reg + 8'd1;
                        sq_step_reg <= 4'd0;
                        if (ci_reg + 8'd1 >= cr_reg) begin
                            state_reg <= ST_DONE;
                        end else begin
                            sq_n_reg <= sq_n_reg;
                            state_reg <= ST_SQRT;
                        end
                    end
                end
                ST_FSPAN: begin
                    // cnt zero with pt marks setup of span seg_reg
                    if (pt_reg == 3'd0) begin
                        {px_reg, py_reg, cnt_reg} <=
                            fspan_setup(seg_reg, x_reg, y_reg, ci_reg, t_reg);
                        pt_reg <= 3'd1;
                    end else if (cnt_reg > 8'd1) begin
                        cnt_reg <= cnt_reg - 8'd1;
                        if (seg_reg[1]) py_reg <= py_reg + 8'd1;
                        else px_reg <= px_reg + 8'd1;
                    end else begin
                        cnt_reg <= 8'd0;
                        pt_reg  <= 3'd0;
                        seg_reg <= seg_reg + 2'd1;
                        if (seg_reg == 2'd3) begin
                            ci_reg <= ci_reg + 8'd1;
                            sq_step_reg <= 4'd0;
                            state_reg <= (ci_reg + 8'd1 >= cr_reg) ? ST_DONE : ST_SQRT;
                        end
                    end
                end
                ST_READ: begin
                    out_reg <= (x_reg < 8'(fsr_pkg::SIDE) && y_reg < 8'(fsr_pkg::SIDE))
                               ? rd_data : 16'd0;
                    out_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_DONE: begin
                    out_reg <= 16'd0;
                    out_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // a setup cycle in filled circles plots nothing
    // (plot_en is gated there by cnt being zero during setup)

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input accepted while busy");
    a_result_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE || state_reg == ST_READ) |=> m_valid)
        else $error("result missing after command end");
    a_clear_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> wr_en)
        else $error("clear sweep skipped a word");

endmodule
